// ===== rtl/czc_pkg.sv =====
// ----------------------------------------------------------------------------
// czc_pkg
// Shared types, verdict codes and collation weight tables for the Czech
// collation comparator.
// ----------------------------------------------------------------------------
package czc_pkg;

    localparam int CHAR_W   = 8;
    localparam int WEIGHT_W = 6;

    typedef logic [CHAR_W-1:0]   t_char;
    typedef logic [WEIGHT_W-1:0] t_weight;
    typedef logic [1:0]          t_verdict;

    localparam t_verdict VERDICT_LESS    = 2'd0;
    localparam t_verdict VERDICT_EQUAL   = 2'd1;
    localparam t_verdict VERDICT_GREATER = 2'd2;

    localparam t_weight CH_WEIGHT = 6'd14;
    localparam t_char   CHAR_UC_C = 8'h43;
    localparam t_char   CHAR_LC_C = 8'h63;
    localparam t_char   CHAR_UC_H = 8'h48;
    localparam t_char   CHAR_LC_H = 8'h68;

    // Weights of one character position of one string.
    typedef struct packed {
        logic    is_end;
        t_weight prim;
        t_weight sec;
    } t_pos;

    // Running decision of one comparison.
    typedef struct packed {
        logic     decided;
        t_verdict prim_v;
        t_verdict sec_v;
    } t_decision;

    localparam t_decision DECISION_RESET = '{
        decided: 1'b0, prim_v: VERDICT_EQUAL, sec_v: VERDICT_EQUAL
    };

    // Primary weight; letters fold case, unmapped bytes weigh zero.
    function automatic t_weight prim_weight(input t_char c);
        t_weight w;
        w = '0;
        case (c)
            8'h41, 8'h61, 8'hC1, 8'hE1: w = 6'd1;
            8'h42, 8'h62:               w = 6'd3;
            8'h43, 8'h63:               w = 6'd4;
            8'hC8, 8'hE8:               w = 6'd5;
            8'h44, 8'h64, 8'hCF, 8'hEF: w = 6'd6;
            8'h45, 8'h65, 8'hC9, 8'hE9,
            8'hCC, 8'hEC:               w = 6'd8;
            8'h46, 8'h66:               w = 6'd11;
            8'h47, 8'h67:               w = 6'd12;
            8'h48, 8'h68:               w = 6'd13;
            8'h49, 8'h69, 8'hCD, 8'hED: w = 6'd15;
            8'h4A, 8'h6A:               w = 6'd17;
            8'h4B, 8'h6B:               w = 6'd18;
            8'h4C, 8'h6C:               w = 6'd19;
            8'h4D, 8'h6D:               w = 6'd20;
            8'h4E, 8'h6E, 8'hD2, 8'hF2: w = 6'd21;
            8'h4F, 8'h6F, 8'hD3, 8'hF3: w = 6'd23;
            8'h50, 8'h70:               w = 6'd25;
            8'h51, 8'h71:               w = 6'd26;
            8'h52, 8'h72:               w = 6'd27;
            8'hD8, 8'hF8:               w = 6'd28;
            8'h53, 8'h73:               w = 6'd29;
            8'hA9, 8'hB9:               w = 6'd30;
            8'h54, 8'h74, 8'hAB, 8'hBB: w = 6'd31;
            8'h55, 8'h75, 8'hDA, 8'hFA,
            8'hD9, 8'hF9:               w = 6'd33;
            8'h56, 8'h76:               w = 6'd36;
            8'h57, 8'h77:               w = 6'd37;
            8'h58, 8'h78:               w = 6'd38;
            8'h59, 8'h79, 8'hDD, 8'hFD: w = 6'd39;
            8'h5A, 8'h7A:               w = 6'd41;
            8'hAE, 8'hBE:               w = 6'd42;
            8'h30: w = 6'd43;
            8'h31: w = 6'd44;
            8'h32: w = 6'd45;
            8'h33: w = 6'd46;
            8'h34: w = 6'd47;
            8'h35: w = 6'd48;
            8'h36: w = 6'd49;
            8'h37: w = 6'd50;
            8'h38: w = 6'd51;
            8'h39: w = 6'd52;
            8'h2E: w = 6'd53;
            8'h2C: w = 6'd54;
            8'h3B: w = 6'd55;
            8'h3F: w = 6'd56;
            8'h21: w = 6'd57;
            8'h3A: w = 6'd58;
            8'h22: w = 6'd59;
            8'h2D: w = 6'd60;
            default: w = '0;
        endcase
        return w;
    endfunction

    // Secondary weight; only accented letters carry one.
    function automatic t_weight sec_weight(input t_char c);
        t_weight w;
        w = '0;
        case (c)
            8'hC1, 8'hE1: w = 6'd2;
            8'hCF, 8'hEF: w = 6'd7;
            8'hC9, 8'hE9: w = 6'd9;
            8'hCC, 8'hEC: w = 6'd10;
            8'hCD, 8'hED: w = 6'd16;
            8'hD2, 8'hF2: w = 6'd22;
            8'hD3, 8'hF3: w = 6'd24;
            8'hAB, 8'hBB: w = 6'd32;
            8'hDA, 8'hFA: w = 6'd34;
            8'hD9, 8'hF9: w = 6'd35;
            8'hDD, 8'hFD: w = 6'd40;
            default:      w = '0;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/czc_lane.sv =====
// ----------------------------------------------------------------------------
// czc_lane
// Weight lookup for one string: the held position, with the CH digraph
// lookahead, and the current position, which has no successor.
// ----------------------------------------------------------------------------
module czc_lane
    import czc_pkg::*;
(
    input  t_char i_held_char,
    input  t_char i_cur_char,
    output t_pos  o_held_pos,
    output t_pos  o_cur_pos
);

    logic w_is_c;
    logic w_next_h;

    assign w_is_c   = (i_held_char == CHAR_UC_C) || (i_held_char == CHAR_LC_C);
    assign w_next_h = (i_cur_char == CHAR_UC_H) || (i_cur_char == CHAR_LC_H);

    always_comb begin
        o_held_pos.is_end = (i_held_char == '0);
        o_held_pos.prim   = (w_is_c && w_next_h) ? CH_WEIGHT : prim_weight(i_held_char);
        o_held_pos.sec    = sec_weight(i_held_char);

        o_cur_pos.is_end  = (i_cur_char == '0);
        o_cur_pos.prim    = prim_weight(i_cur_char);
        o_cur_pos.sec     = sec_weight(i_cur_char);
    end

endmodule

// ===== rtl/czc_merge.sv =====
// ----------------------------------------------------------------------------
// czc_merge
// Combines the two lanes' weights into the running decision: the held
// position first, then, on the final word, the current position.
// ----------------------------------------------------------------------------
module czc_merge
    import czc_pkg::*;
(
    input  t_decision i_dec,
    input  logic      i_held_valid,
    input  logic      i_final,
    input  t_pos      i_src_held,
    input  t_pos      i_dst_held,
    input  t_pos      i_src_cur,
    input  t_pos      i_dst_cur,
    output t_decision o_dec,
    output t_verdict  o_verdict
);

    function automatic t_decision step(input t_decision d, input t_pos a, input t_pos b);
        t_decision r;
        r = d;
        if (!(a.is_end && b.is_end) && !d.decided) begin
            if (a.is_end || b.is_end) begin
                r.decided = 1'b1;
                r.prim_v  = a.is_end ? VERDICT_LESS : VERDICT_GREATER;
            end else if (a.prim != b.prim) begin
                r.decided = 1'b1;
                r.prim_v  = (a.prim < b.prim) ? VERDICT_LESS : VERDICT_GREATER;
            end else if (a.sec > b.sec) begin
                r.sec_v = VERDICT_GREATER;
            end else if (a.sec < b.sec) begin
                r.sec_v = VERDICT_LESS;
            end
        end
        return r;
    endfunction

    t_decision w_after_held;

    always_comb begin
        w_after_held = i_held_valid ? step(i_dec, i_src_held, i_dst_held) : i_dec;
        o_dec        = i_final ? step(w_after_held, i_src_cur, i_dst_cur) : w_after_held;
        o_verdict    = o_dec.decided ? o_dec.prim_v : o_dec.sec_v;
    end

endmodule

// ===== rtl/czech_collation_compare_core.sv =====
// ----------------------------------------------------------------------------
// czech_collation_compare_core
// Simplified Czech collation comparison of two ISO-8859-2 strings, one
// character pair per input word, one verdict per comparison.
// ----------------------------------------------------------------------------
// Usage: each input word carries the next byte of both strings; a zero byte
// ends a string, and every later byte of that string is read as zero. The
// word with i_final_pair high closes the comparison. Nothing comes out for
// other words; for the final word one output word carries o_verdict (less,
// equal or greater, first string against second).
// Both channels are valid/ready. Each pair is held inside the block
// until its successor arrives, because a C followed by H forms the CH digraph.
// Throughput is one word per cycle while no final word waits; the per-pair
// work is two lane lookups of the constant weight tables and one merge of
// small compares, all combinational. The verdict is registered and shows on
// o_out_valid in the cycle after the final word is accepted.
// A non-final word is always accepted, since it produces no output. A final
// word waits only while an earlier verdict is still in the output register
// and the receiver holds i_out_ready low; when the receiver takes it in the
// same cycle, the new verdict replaces it without a gap.
// Reset (synchronous, active low) clears the held pair, the end-of-string
// flags and the running decision, and empties the output register. Each final
// word clears the first three in the same way and fills the output register.
// ----------------------------------------------------------------------------
module czech_collation_compare_core
    import czc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_char    i_src_char,
    input  t_char    i_dst_char,
    input  logic     i_final_pair,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_verdict o_verdict
);

    // Held pair, per-string end flags, running decision and output register.
    t_char     r_held_src, n_held_src;
    t_char     r_held_dst, n_held_dst;
    logic      r_held_valid, n_held_valid;
    logic      r_src_done, n_src_done;
    logic      r_dst_done, n_dst_done;
    t_decision r_dec, n_dec;
    logic      r_out_valid, n_out_valid;
    t_verdict  r_verdict, n_verdict;

    logic      w_accept;
    t_char     w_src_eff;
    t_char     w_dst_eff;
    t_pos      w_src_held, w_src_cur;
    t_pos      w_dst_held, w_dst_cur;
    t_decision w_dec_next;
    t_verdict  w_verdict;

    // A final word needs the output register free, or freed this cycle.
    assign o_in_ready = !i_final_pair || !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // Bytes after a string's end count as zero.
    assign w_src_eff = r_src_done ? '0 : i_src_char;
    assign w_dst_eff = r_dst_done ? '0 : i_dst_char;

    czc_lane u_lane_src (
        .i_held_char (r_held_src),
        .i_cur_char  (w_src_eff),
        .o_held_pos  (w_src_held),
        .o_cur_pos   (w_src_cur)
    );

    czc_lane u_lane_dst (
        .i_held_char (r_held_dst),
        .i_cur_char  (w_dst_eff),
        .o_held_pos  (w_dst_held),
        .o_cur_pos   (w_dst_cur)
    );

    czc_merge u_merge (
        .i_dec        (r_dec),
        .i_held_valid (r_held_valid),
        .i_final      (i_final_pair),
        .i_src_held   (w_src_held),
        .i_dst_held   (w_dst_held),
        .i_src_cur    (w_src_cur),
        .i_dst_cur    (w_dst_cur),
        .o_dec        (w_dec_next),
        .o_verdict    (w_verdict)
    );

    always_comb begin
        n_held_src   = r_held_src;
        n_held_dst   = r_held_dst;
        n_held_valid = r_held_valid;
        n_src_done   = r_src_done;
        n_dst_done   = r_dst_done;
        n_dec        = r_dec;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_verdict    = r_verdict;

        if (w_accept) begin
            if (i_final_pair) begin
                // Comparison closes: emit and return to the idle state.
                n_out_valid  = 1'b1;
                n_verdict    = w_verdict;
                n_held_src   = '0;
                n_held_dst   = '0;
                n_held_valid = 1'b0;
                n_src_done   = 1'b0;
                n_dst_done   = 1'b0;
                n_dec        = DECISION_RESET;
            end else begin
                n_held_src   = w_src_eff;
                n_held_dst   = w_dst_eff;
                n_held_valid = 1'b1;
                n_src_done   = r_src_done || (w_src_eff == '0);
                n_dst_done   = r_dst_done || (w_dst_eff == '0);
                n_dec        = w_dec_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_src   <= '0;
            r_held_dst   <= '0;
            r_held_valid <= 1'b0;
            r_src_done   <= 1'b0;
            r_dst_done   <= 1'b0;
            r_dec        <= DECISION_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_held_src   <= n_held_src;
            r_held_dst   <= n_held_dst;
            r_held_valid <= n_held_valid;
            r_src_done   <= n_src_done;
            r_dst_done   <= n_dst_done;
            r_dec        <= n_dec;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_verdict <= n_verdict;
    end

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

`ifndef ASSERT_OFF
    // With no pair held, no comparison has begun, so the decision is idle.
    a_idle_decision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_held_valid |-> (!r_dec.decided && r_dec.sec_v == VERDICT_EQUAL))
        else $error("decision not idle while no pair is held");

    // An ended string holds a zero byte in its held slot.
    a_src_done_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_src_done |-> (r_held_valid && r_held_src == '0))
        else $error("source ended but held byte is not zero");

    a_dst_done_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dst_done |-> (r_held_valid && r_held_dst == '0))
        else $error("destination ended but held byte is not zero");

    // A primary decision is always strict.
    a_primary_strict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dec.decided |-> (r_dec.prim_v == VERDICT_LESS || r_dec.prim_v == VERDICT_GREATER))
        else $error("primary decision recorded as equal");

    // Every accepted final word produces a verdict in the next cycle.
    a_final_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_final_pair) |=> (o_out_valid && o_verdict != 2'd3))
        else $error("final word did not produce a valid verdict");
`endif

endmodule

// ===== verif/czech_collation_compare_core_tb.sv =====
// ----------------------------------------------------------------------------
// czech_collation_compare_core_tb
// Self-checking testbench for the Czech collation comparator.
// ----------------------------------------------------------------------------
// Character pairs are streamed into the block as input words, with random
// bursts and gaps on the sending side and a changing stall pattern on the
// receiving side. A collation predictor inside the testbench mirrors the
// block's behavior on every accepted word. Each verdict that comes out is
// compared with the oldest verdict that the predictor has queued. A short
// directed part covers ordering, the CH digraph, string ends, unmapped bytes
// and accent weights. A long random part follows, made mostly of related
// string pairs.
// ----------------------------------------------------------------------------
module czech_collation_compare_core_tb;
    import czc_pkg::*;

    localparam int RANDOM_PAIRS = 1700;
    localparam int MAX_SHOWN    = 10;

    localparam t_char LETTER_UC_A = 8'h41;
    localparam t_char LETTER_LC_A = 8'h61;

    // Receiver stall patterns; one is picked at random for each stretch.
    typedef enum logic [1:0] {
        RX_STREAM,
        RX_RANDOM,
        RX_COMB,
        RX_RUNS
    } t_rx_mode;

    logic     i_clk        = 1'b0;
    logic     i_rst_n      = 1'b0;
    logic     i_in_valid   = 1'b0;
    logic     o_in_ready;
    t_char    i_src_char   = '0;
    t_char    i_dst_char   = '0;
    logic     i_final_pair = 1'b0;
    logic     o_out_valid;
    logic     i_out_ready  = 1'b0;
    t_verdict o_verdict;

    czech_collation_compare_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_src_char   (i_src_char),
        .i_dst_char   (i_dst_char),
        .i_final_pair (i_final_pair),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_verdict    (o_verdict)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Collation predictor state.
    // ------------------------------------------------------------------------
    // The weight tables are built here from the collation order, not taken
    // from the package, so that a wrong table entry in the RTL shows up.
    t_weight prim_tab [256];
    t_weight sec_tab  [256];

    // A pair is held back until its successor arrives, because the next
    // byte of the same string decides whether a C starts the CH digraph.
    t_char    held_src;
    t_char    held_dst;
    logic     held_valid;
    logic     src_ended;
    logic     dst_ended;
    logic     prim_decided;
    t_verdict prim_verdict;
    t_verdict sec_verdict;

    t_verdict expected_verdicts [$];

    int pairs_sent     = 0;
    int verdicts_seen  = 0;
    int mismatch_count = 0;
    int burst_left     = 0;

    t_verdict want_verdict;
    t_rx_mode rx_mode      = RX_STREAM;
    int       rx_mode_left = 0;
    int       rx_cycle     = 0;
    int       rx_run_left  = 0;
    logic     rx_run_high  = 1'b1;

    // Byte pools for the random strings: mapped accented letters of the
    // ISO-8859-2 range, and the digits and punctuation that carry a weight.
    t_char accent_set [$] = '{
        8'hC1, 8'hE1, 8'hC8, 8'hE8, 8'hCF, 8'hEF, 8'hC9, 8'hE9, 8'hCC, 8'hEC,
        8'hCD, 8'hED, 8'hD2, 8'hF2, 8'hD3, 8'hF3, 8'hD8, 8'hF8, 8'hA9, 8'hB9,
        8'hAB, 8'hBB, 8'hDA, 8'hFA, 8'hD9, 8'hF9, 8'hDD, 8'hFD, 8'hAE, 8'hBE
    };
    t_char sym_set [$] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
        8'h2E, 8'h2C, 8'h3B, 8'h3F, 8'h21, 8'h3A, 8'h22, 8'h2D
    };

    task automatic set_weights(input t_char up, input t_char lo, input int p, input int s);
        prim_tab[up] = t_weight'(p);
        prim_tab[lo] = t_weight'(p);
        sec_tab[up]  = t_weight'(s);
        sec_tab[lo]  = t_weight'(s);
    endtask

    task automatic build_weight_tables();
        for (int i = 0; i < 256; i++) begin
            prim_tab[i] = '0;
            sec_tab[i]  = '0;
        end
        // Letters fold case; accented forms share the primary weight of
        // their base letter and differ only in the secondary weight, except
        // where Czech treats the accented letter as a letter of its own.
        set_weights("A", "a", 1, 0);    set_weights(8'hC1, 8'hE1, 1, 2);
        set_weights("B", "b", 3, 0);
        set_weights("C", "c", 4, 0);    set_weights(8'hC8, 8'hE8, 5, 0);
        set_weights("D", "d", 6, 0);    set_weights(8'hCF, 8'hEF, 6, 7);
        set_weights("E", "e", 8, 0);    set_weights(8'hC9, 8'hE9, 8, 9);
        set_weights(8'hCC, 8'hEC, 8, 10);
        set_weights("F", "f", 11, 0);   set_weights("G", "g", 12, 0);
        set_weights("H", "h", 13, 0);
        set_weights("I", "i", 15, 0);   set_weights(8'hCD, 8'hED, 15, 16);
        set_weights("J", "j", 17, 0);   set_weights("K", "k", 18, 0);
        set_weights("L", "l", 19, 0);   set_weights("M", "m", 20, 0);
        set_weights("N", "n", 21, 0);   set_weights(8'hD2, 8'hF2, 21, 22);
        set_weights("O", "o", 23, 0);   set_weights(8'hD3, 8'hF3, 23, 24);
        set_weights("P", "p", 25, 0);   set_weights("Q", "q", 26, 0);
        set_weights("R", "r", 27, 0);   set_weights(8'hD8, 8'hF8, 28, 0);
        set_weights("S", "s", 29, 0);   set_weights(8'hA9, 8'hB9, 30, 0);
        set_weights("T", "t", 31, 0);   set_weights(8'hAB, 8'hBB, 31, 32);
        set_weights("U", "u", 33, 0);   set_weights(8'hDA, 8'hFA, 33, 34);
        set_weights(8'hD9, 8'hF9, 33, 35);
        set_weights("V", "v", 36, 0);   set_weights("W", "w", 37, 0);
        set_weights("X", "x", 38, 0);
        set_weights("Y", "y", 39, 0);   set_weights(8'hDD, 8'hFD, 39, 40);
        set_weights("Z", "z", 41, 0);   set_weights(8'hAE, 8'hBE, 42, 0);
        // Digits and punctuation sort after all letters.
        for (int i = 0; i < sym_set.size(); i++) begin
            set_weights(sym_set[i], sym_set[i], 43 + i, 0);
        end
    endtask

    task automatic clear_prediction();
        held_src     = '0;
        held_dst     = '0;
        held_valid   = 1'b0;
        src_ended    = 1'b0;
        dst_ended    = 1'b0;
        prim_decided = 1'b0;
        prim_verdict = VERDICT_EQUAL;
        sec_verdict  = VERDICT_EQUAL;
    endtask

    function automatic t_weight primary_of(input t_char c, input t_char nxt);
        if ((c == CHAR_UC_C || c == CHAR_LC_C) && (nxt == CHAR_UC_H || nxt == CHAR_LC_H)) begin
            return CH_WEIGHT;
        end
        return prim_tab[c];
    endfunction

    // Compares one character position of both strings; nxt_a and nxt_b are
    // the following bytes of the same strings, used for the digraph only.
    task automatic weigh_position(input t_char a, input t_char b,
                                  input t_char nxt_a, input t_char nxt_b);
        t_weight pa;
        t_weight pb;
        pa = primary_of(a, nxt_a);
        pb = primary_of(b, nxt_b);
        // Positions past both ends, and everything after the first primary
        // difference, leave the decision alone.
        if (!(a == '0 && b == '0) && !prim_decided) begin
            if (a == '0 || b == '0) begin
                // The string that ended first is less, even when the other
                // one only holds unmapped bytes.
                prim_decided = 1'b1;
                prim_verdict = (a == '0) ? VERDICT_LESS : VERDICT_GREATER;
            end else if (pa != pb) begin
                prim_decided = 1'b1;
                prim_verdict = (pa < pb) ? VERDICT_LESS : VERDICT_GREATER;
            end else if (sec_tab[a] > sec_tab[b]) begin
                sec_verdict = VERDICT_GREATER;
            end else if (sec_tab[a] < sec_tab[b]) begin
                sec_verdict = VERDICT_LESS;
            end
        end
    endtask

    // Runs for every accepted input word and queues the verdict of a final one.
    task automatic predict_collation(input t_char s, input t_char d, input logic fin);
        t_char es;
        t_char ed;
        // Once a string has shown its terminator, later bytes count as zero.
        es = src_ended ? '0 : s;
        ed = dst_ended ? '0 : d;
        if (es == '0) src_ended = 1'b1;
        if (ed == '0) dst_ended = 1'b1;
        if (held_valid) weigh_position(held_src, held_dst, es, ed);
        if (fin) begin
            // Nothing follows a final pair, so a C in it never forms CH.
            weigh_position(es, ed, '0, '0);
            expected_verdicts.push_back(prim_decided ? prim_verdict : sec_verdict);
            clear_prediction();
        end else begin
            held_src   = es;
            held_dst   = ed;
            held_valid = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sending side.
    // ------------------------------------------------------------------------
    // Offers one character pair and returns at the edge where the block
    // accepts it. Between bursts the sender drops valid for a random gap;
    // a zero gap keeps the stream running back to back.
    task automatic send_char_pair(input t_char s, input t_char d, input logic fin);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 60);
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_src_char   <= s;
        i_dst_char   <= d;
        i_final_pair <= fin;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_collation(s, d, fin);
        pairs_sent++;
    endtask

    // Holds the sender off until every queued verdict has come out. The
    // first edge is always waited for, so valid never falls and rises in
    // the same step.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (expected_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // Streams two ASCII strings, padded with terminators to equal length;
    // the last pair is marked final.
    task automatic send_strings(input string a, input string b);
        int    n;
        t_char s;
        t_char d;
        n = (a.len() > b.len()) ? a.len() : b.len();
        if (n == 0) n = 1;
        for (int i = 0; i < n; i++) begin
            s = (i < a.len()) ? t_char'(a[i]) : '0;
            d = (i < b.len()) ? t_char'(b[i]) : '0;
            send_char_pair(s, d, i == n - 1);
        end
    endtask

    function automatic t_char pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            return t_char'($urandom_range(0, 25))
                + (($urandom_range(0, 1) != 0) ? LETTER_UC_A : LETTER_LC_A);
        end
        if (r < 55) begin
            // C and H come often so that the digraph forms in many places.
            case ($urandom_range(0, 3))
                0:       return CHAR_UC_C;
                1:       return CHAR_LC_C;
                2:       return CHAR_UC_H;
                default: return CHAR_LC_H;
            endcase
        end
        if (r < 75) return accent_set[$urandom_range(0, accent_set.size() - 1)];
        if (r < 88) return sym_set[$urandom_range(0, sym_set.size() - 1)];
        return t_char'($urandom_range(1, 255));
    endfunction

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------
    task automatic test_plain_order();
        send_strings("abc", "abd");
        send_strings("B", "a");
        send_strings("", "");
    endtask

    task automatic test_ch_digraph();
        // CH sorts after H, so "ch" beats "d" and a lone c loses to ch.
        send_strings("ch", "d");
        send_strings("c", "CH");
        // A c in the final word is weighed as a plain c.
        send_strings("ac", "ad");
    endtask

    task automatic test_string_ends();
        send_strings("ab", "abc");
        // After the first string ends, its later bytes are ignored; the
        // position where both have ended changes nothing.
        send_char_pair("a", "a", 1'b0);
        send_char_pair('0, "a", 1'b0);
        send_char_pair("z", '0, 1'b1);
        // An unmapped byte still beats a string that has ended.
        send_char_pair(8'h01, '0, 1'b1);
    endtask

    task automatic test_unmapped_bytes();
        send_char_pair(8'hFF, 8'h01, 1'b1);
        send_char_pair(8'h80, 8'hFF, 1'b1);
    endtask

    task automatic test_secondary_weights();
        // Primaries tie throughout; the last accent difference decides.
        send_char_pair(8'hE1, "a", 1'b0);
        send_char_pair("A", 8'hC1, 1'b1);
        send_char_pair(8'hCC, 8'hC9, 1'b1);
    endtask

    // Mostly pairs of related strings, so that comparisons get past the
    // first positions and down to the accents; some are cut short before
    // the terminators, carry junk after them, or are plain noise.
    task automatic test_random_comparisons();
        t_char src_q [$];
        t_char dst_q [$];
        t_char s;
        t_char d;
        int    start;
        int    kind;
        int    span;
        int    idx;
        start = pairs_sent;
        while (pairs_sent - start < RANDOM_PAIRS) begin
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                span = $urandom_range(1, 5);
                for (int i = 0; i < span; i++) begin
                    send_char_pair(t_char'($urandom_range(0, 255)),
                                   t_char'($urandom_range(0, 255)), i == span - 1);
                end
            end else begin
                src_q.delete();
                dst_q.delete();
                span = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                   : $urandom_range(0, 6);
                repeat (span) src_q.push_back(pick_char());
                if (kind < 75) begin
                    dst_q = src_q;
                    // A copy with a few edits; below 23 it stays identical.
                    if (kind >= 23) begin
                        repeat ($urandom_range(1, 2)) begin
                            idx = (dst_q.size() == 0) ? 0 : $urandom_range(0, dst_q.size() - 1);
                            case ($urandom_range(0, 4))
                                0: if (dst_q.size() != 0) dst_q[idx] = pick_char();
                                1: if (dst_q.size() != 0 && (dst_q[idx] | 8'h20) >= 8'h61
                                       && (dst_q[idx] | 8'h20) <= 8'h7A) begin
                                       dst_q[idx] = dst_q[idx] ^ 8'h20;
                                   end
                                2: if (dst_q.size() != 0) begin
                                       dst_q[idx] = accent_set[$urandom_range(0,
                                                    accent_set.size() - 1)];
                                   end
                                3: if (dst_q.size() != 0) void'(dst_q.pop_back());
                                default: dst_q.push_back(pick_char());
                            endcase
                        end
                    end
                end else begin
                    repeat ($urandom_range(0, 6)) dst_q.push_back(pick_char());
                end
                span = ((src_q.size() > dst_q.size()) ? src_q.size() : dst_q.size())
                     + $urandom_range(0, 2);
                if (span == 0) span = 1;
                if (kind >= 90) span = $urandom_range(1, span);
                for (int i = 0; i < span; i++) begin
                    if (i < src_q.size()) s = src_q[i];
                    else if (i > src_q.size() && $urandom_range(0, 2) == 0)
                        s = t_char'($urandom_range(1, 255));
                    else s = '0;
                    if (i < dst_q.size()) d = dst_q[i];
                    else if (i > dst_q.size() && $urandom_range(0, 2) == 0)
                        d = t_char'($urandom_range(1, 255));
                    else d = '0;
                    send_char_pair(s, d, i == span - 1);
                end
            end
            if ($urandom_range(0, 39) == 0) wait_for_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiving side: checks every verdict word and drives the stall pattern.
    // ------------------------------------------------------------------------
    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN) $display("%0t: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_verdicts.size() == 0) begin
                note_failure($sformatf("verdict %0d with no comparison pending", o_verdict));
            end else begin
                want_verdict = expected_verdicts.pop_front();
                if (o_verdict !== want_verdict) begin
                    note_failure($sformatf("verdict %0d: expected %0d, got %0d",
                                           verdicts_seen, want_verdict, o_verdict));
                end
            end
            verdicts_seen++;
        end

        if (rx_mode_left == 0) begin
            rx_mode      = t_rx_mode'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(32, 256);
        end
        rx_mode_left--;
        rx_cycle++;
        case (rx_mode)
            RX_STREAM: i_out_ready <= 1'b1;
            RX_RANDOM: i_out_ready <= ($urandom_range(0, 3) != 0);
            RX_COMB:   i_out_ready <= ((rx_cycle % 5) < 3);
            default: begin
                if (rx_run_left == 0) begin
                    rx_run_high = !rx_run_high;
                    rx_run_left = $urandom_range(1, 12);
                end
                rx_run_left--;
                i_out_ready <= rx_run_high;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        build_weight_tables();
        clear_prediction();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_plain_order();
        test_ch_digraph();
        wait_for_results();
        test_string_ends();
        test_unmapped_bytes();
        test_secondary_weights();
        wait_for_results();
        test_random_comparisons();

        // The verdict is registered; the wait here catches any late word.
        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/czc_pkg.sv
rtl/czc_lane.sv
rtl/czc_merge.sv
rtl/czech_collation_compare_core.sv
verif/czech_collation_compare_core_tb.sv
